[rtl/reorder_window_receiver_assert.svh]
// assertion macros for the reorder window receiver
// used by the back part to check its own control logic, empty for synthesis
`ifndef REORDER_WINDOW_RECEIVER_ASSERT_SVH
`define REORDER_WINDOW_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define RWR_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rwr assertion failed");
`define RWR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rwr assertion failed");
`else
`define RWR_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define RWR_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

[rtl/rwr_pkg.sv]
// shared types and constants for the reorder window receiver
// no dependencies
package rwr_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);

    localparam int SEQ_W    = 32;
    localparam int LEN_W    = 11;
    localparam int HANDLE_W = 16;
    localparam int MAGIC_W  = 32;
    localparam int SLOT_W   = LEN_W + HANDLE_W;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(1500);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_EXPECTED_MAGIC = '0;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic                eof;
        logic [HANDLE_W-1:0] handle;
    } t_desc;

endpackage

[rtl/rwr_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module rwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/rwr_queue.sv]
// short descriptor queue between the front and back parts
// depends on rwr_pkg
module rwr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rwr_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rwr_pkg::t_desc o_desc
);
    import rwr_pkg::*;

    t_desc              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/rwr_front.sv]
// front part: takes input items, drops foreign magic, clamps length
// depends on rwr_pkg
module rwr_front (
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rwr_pkg::MAGIC_W-1:0]   i_magic_value,
    input  logic [rwr_pkg::SEQ_W-1:0]     i_seq_number,
    input  logic [rwr_pkg::LEN_W-1:0]     i_payload_length,
    input  logic                          i_end_flag,
    input  logic [rwr_pkg::HANDLE_W-1:0]  i_payload_handle,
    input  logic [rwr_pkg::MAGIC_W-1:0]   i_expected_magic,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rwr_pkg::t_desc                o_desc
);
    import rwr_pkg::*;

    logic magic_ok;

    assign magic_ok   = (i_magic_value == i_expected_magic);
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && magic_ok;

    always_comb begin
        o_desc.seq    = i_seq_number;
        o_desc.len    = (i_payload_length > MAX_LEN) ? MAX_LEN : i_payload_length;
        o_desc.eof    = i_end_flag;
        o_desc.handle = i_payload_handle;
    end

endmodule

[rtl/rwr_back.sv]
// back part: window check, slot store, in-order delivery, drain and ack
// depends on rwr_pkg, rwr_ram and the assertion macro header
`include "reorder_window_receiver_assert.svh"
module rwr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  rwr_pkg::t_desc                i_q_desc,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_result_kind,
    output logic [rwr_pkg::SEQ_W-1:0]     o_out_sequence,
    output logic [rwr_pkg::LEN_W-1:0]     o_out_length,
    output logic [rwr_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic                          o_out_eof,
    output logic                          o_last_of_run
);
    import rwr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_HEAD,
        S_CHECK,
        S_DRAIN,
        S_ACK
    } t_state;

    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(WINDOW_DEPTH - 1);

    t_state                 r_state;
    logic [SEQ_W-1:0]       r_next;
    logic                   r_finished;
    logic [WINDOW_DEPTH-1:0] r_valid;
    t_desc                  r_desc;
    logic [IDX_W-1:0]       r_steps;
    logic                   r_out_valid;
    logic                   r_kind;
    logic [SEQ_W-1:0]       r_oseq;
    logic [LEN_W-1:0]       r_olen;
    logic [HANDLE_W-1:0]    r_ohandle;
    logic                   r_oeof;
    logic                   r_olast;

    logic [SEQ_W-1:0]       n_next;
    logic [SEQ_W-1:0]       seq_gap;
    logic [IDX_W-1:0]       head_idx;
    logic [IDX_W-1:0]       seq_idx;
    logic                   below;
    logic                   in_order;
    logic                   in_win;
    logic                   park;
    logic                   out_free;
    logic                   ld_ack;
    logic [SLOT_W-1:0]      rd_data;
    logic [LEN_W-1:0]       rd_len;
    logic [HANDLE_W-1:0]    rd_handle;

    assign n_next   = r_next + SEQ_W'(1);
    assign seq_gap  = r_desc.seq - r_next;
    assign head_idx = r_next[IDX_W-1:0];
    assign seq_idx  = r_desc.seq[IDX_W-1:0];
    assign below    = (r_desc.seq < r_next);
    assign in_order = (r_desc.seq == r_next);
    assign in_win   = (seq_gap < SEQ_W'(WINDOW_DEPTH));
    assign park     = (r_state == S_CLASSIFY) && !r_finished && !below && !in_order
                      && in_win && !r_valid[seq_idx] && (r_desc.len != '0);
    assign out_free = !r_out_valid || i_out_ready;
    assign ld_ack   = (r_state == S_ACK) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign rd_len    = rd_data[SLOT_W-1:HANDLE_W];
    assign rd_handle = rd_data[HANDLE_W-1:0];

    rwr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (park),
        .i_wr_addr (seq_idx),
        .i_wr_data ({r_desc.len, r_desc.handle}),
        .i_rd_en   (r_state == S_CHECK),
        .i_rd_addr (head_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= SEQ_W'(1);
            r_finished  <= 1'b0;
            r_valid     <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_desc  <= i_q_desc;
                        r_state <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY: begin
                    priority if (r_finished || below) begin
                        r_state <= S_IDLE;
                    end else if (in_order) begin
                        r_state <= S_HEAD;
                    end else if (!in_win) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (park) begin
                            r_valid[seq_idx] <= 1'b1;
                        end
                        r_state <= S_ACK;
                    end
                end
                S_HEAD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_DELIVER;
                        r_oseq      <= r_desc.seq;
                        r_olen      <= r_desc.len;
                        r_ohandle   <= r_desc.handle;
                        r_oeof      <= 1'b0;
                        r_olast     <= 1'b0;
                        r_next      <= n_next;
                        r_steps     <= '0;
                        r_state     <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_steps != STEP_LAST && r_valid[head_idx]) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_state <= S_ACK;
                    end
                end
                S_DRAIN: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_kind            <= KIND_DELIVER;
                        r_oseq            <= r_next;
                        r_olen            <= rd_len;
                        r_ohandle         <= rd_handle;
                        r_oeof            <= 1'b0;
                        r_olast           <= 1'b0;
                        r_valid[head_idx] <= 1'b0;
                        r_next            <= n_next;
                        r_steps           <= r_steps + IDX_W'(1);
                        r_state           <= S_CHECK;
                    end
                end
                S_ACK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_ACK;
                        r_oseq      <= r_next - SEQ_W'(1);
                        r_olen      <= '0;
                        r_ohandle   <= '0;
                        r_oeof      <= r_desc.eof;
                        r_olast     <= 1'b1;
                        if (r_desc.eof) begin
                            r_finished <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_out_sequence = r_oseq;
    assign o_out_length   = r_olen;
    assign o_out_handle   = r_ohandle;
    assign o_out_eof      = r_oeof;
    assign o_last_of_run  = r_olast;

    // slot of the next expected sequence is never occupied between items
    `RWR_ASSERT_IMPL(a_head_slot_clear, i_clk, i_rst_n, r_state == S_IDLE, !r_valid[head_idx])
    // after eof nothing gets past classification
    `RWR_ASSERT_IMPL(a_finished_quiet, i_clk, i_rst_n, r_finished,
        r_state == S_IDLE || r_state == S_CLASSIFY)
    // only the ack closes a run
    `RWR_ASSERT_IMPL(a_ack_is_last, i_clk, i_rst_n, r_out_valid, r_kind == r_olast)
    // an eof ack locks the receiver
    `RWR_ASSERT_NEXT(a_eof_locks, i_clk, i_rst_n, ld_ack && r_desc.eof, r_finished)

endmodule

[rtl/reorder_window_receiver.sv]
// reorder window receiver: the back state machine passes a dropped item through
// classify, a parked item through classify and ack, and an in-order item through
// classify, head, a check and a drain per stored slot with one read each, then ack
// reset is synchronous active low: window empty, next sequence 1, magic 0
// a two-item queue lets input items be taken while the back part works
// depends on rwr_pkg, rwr_front, rwr_queue, rwr_back
module reorder_window_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rwr_pkg::MAGIC_W-1:0]   i_magic_value,
    input  logic [rwr_pkg::SEQ_W-1:0]     i_seq_number,
    input  logic [rwr_pkg::LEN_W-1:0]     i_payload_length,
    input  logic                          i_end_flag,
    input  logic [rwr_pkg::HANDLE_W-1:0]  i_payload_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_result_kind,
    output logic [rwr_pkg::SEQ_W-1:0]     o_out_sequence,
    output logic [rwr_pkg::LEN_W-1:0]     o_out_length,
    output logic [rwr_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic                          o_out_eof,
    output logic                          o_last_of_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwr_pkg::PADDR_W-1:0]   paddr,
    input  logic [rwr_pkg::PDATA_W-1:0]   pwdata,
    output logic [rwr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import rwr_pkg::*;

    logic [MAGIC_W-1:0] r_expected_magic;
    logic               cfg_wr;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    t_desc              push_desc;
    t_desc              pop_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_EXPECTED_MAGIC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= '0;
        end else if (cfg_wr) begin
            r_expected_magic <= pwdata[MAGIC_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_EXPECTED_MAGIC) ? r_expected_magic : '0;

    rwr_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_magic_value    (i_magic_value),
        .i_seq_number     (i_seq_number),
        .i_payload_length (i_payload_length),
        .i_end_flag       (i_end_flag),
        .i_payload_handle (i_payload_handle),
        .i_expected_magic (r_expected_magic),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_desc           (push_desc)
    );

    rwr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (pop_desc)
    );

    rwr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_desc       (pop_desc),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_out_sequence (o_out_sequence),
        .o_out_length   (o_out_length),
        .o_out_handle   (o_out_handle),
        .o_out_eof      (o_out_eof),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

[tb/sv/rwr_checker.sv]
`timescale 1ns / 1ps
// result checker for the reorder window receiver: follows register writes and
// accepted packet descriptors, predicts results and compares each one by field
// depends on rwr_pkg only
module rwr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [rwr_pkg::MAGIC_W-1:0]   i_magic_value,
    input  logic [rwr_pkg::SEQ_W-1:0]     i_seq_number,
    input  logic [rwr_pkg::LEN_W-1:0]     i_payload_length,
    input  logic                          i_end_flag,
    input  logic [rwr_pkg::HANDLE_W-1:0]  i_payload_handle,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_result_kind,
    input  logic [rwr_pkg::SEQ_W-1:0]     i_out_sequence,
    input  logic [rwr_pkg::LEN_W-1:0]     i_out_length,
    input  logic [rwr_pkg::HANDLE_W-1:0]  i_out_handle,
    input  logic                          i_out_eof,
    input  logic                          i_last_of_run,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [rwr_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [rwr_pkg::PDATA_W-1:0]   i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);
    import rwr_pkg::*;

    typedef struct packed {
        logic                kind;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
        logic                eof;
        logic                last;
    } t_result;

    logic [MAGIC_W-1:0]  magic_cfg;
    logic [SEQ_W-1:0]    next_seq;
    logic [LEN_W-1:0]    slot_len [WINDOW_DEPTH];
    logic [HANDLE_W-1:0] slot_hdl [WINDOW_DEPTH];
    logic                eof_seen;
    t_result             awaited_results [$];
    int                  fails = 0;
    int                  checked = 0;

    task automatic await_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                input logic [LEN_W-1:0] len,
                                input logic [HANDLE_W-1:0] handle,
                                input logic eof, input logic last);
        t_result r;
        r.kind   = kind;
        r.seq    = seq;
        r.len    = len;
        r.handle = handle;
        r.eof    = eof;
        r.last   = last;
        awaited_results.push_back(r);
    endtask

    // in-order delivery, window drain, parking and the closing cumulative ack
    task automatic absorb_packet(input logic [MAGIC_W-1:0] magic,
                                 input logic [SEQ_W-1:0] seq,
                                 input logic [LEN_W-1:0] raw_len, input logic eof,
                                 input logic [HANDLE_W-1:0] handle);
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq_gap;
        logic [IDX_W-1:0] idx;
        int               walked;
        if (eof_seen || magic != magic_cfg) return;
        len = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;
        if (seq < next_seq) return;
        if (seq == next_seq) begin
            await_result(KIND_DELIVER, seq, len, handle, 1'b0, 1'b0);
            next_seq = next_seq + 1'b1;
            walked = 0;
            while (walked < WINDOW_DEPTH - 1 && slot_len[next_seq[IDX_W-1:0]] != '0) begin
                idx = next_seq[IDX_W-1:0];
                await_result(KIND_DELIVER, next_seq, slot_len[idx], slot_hdl[idx], 1'b0, 1'b0);
                slot_len[idx] = '0;
                next_seq = next_seq + 1'b1;
                walked++;
            end
        end else begin
            seq_gap = seq - next_seq;
            if (seq_gap >= WINDOW_DEPTH) return;
            idx = seq[IDX_W-1:0];
            if (slot_len[idx] == '0) begin
                slot_len[idx] = len;
                slot_hdl[idx] = handle;
            end
        end
        await_result(KIND_ACK, next_seq - 1'b1, '0, '0, eof, 1'b1);
        if (eof) eof_seen = 1'b1;
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            magic_cfg = '0;
            next_seq  = 32'd1;
            eof_seen  = 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                slot_len[i] = '0;
                slot_hdl[i] = '0;
            end
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[PADDR_W-1:2] == REG_EXPECTED_MAGIC)
                magic_cfg = i_pwdata[MAGIC_W-1:0];
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual kind %0b seq %0h",
                             $time, i_result_kind, i_out_sequence);
                    fails++;
                end else begin
                    r = awaited_results.pop_front();
                    fails += field_differs("result_kind", 32'(r.kind), 32'(i_result_kind))
                           + field_differs("out_sequence", 32'(r.seq), 32'(i_out_sequence))
                           + field_differs("out_length", 32'(r.len), 32'(i_out_length))
                           + field_differs("out_handle", 32'(r.handle), 32'(i_out_handle))
                           + field_differs("out_eof", 32'(r.eof), 32'(i_out_eof))
                           + field_differs("last_of_run", 32'(r.last), 32'(i_last_of_run));
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_packet(i_magic_value, i_seq_number, i_payload_length, i_end_flag,
                              i_payload_handle);
        end
        o_fail_count   <= fails;
        o_pending      <= awaited_results.size();
        o_result_count <= checked;
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// top testbench for the reorder window receiver: clock, reset, register writes
// and packet descriptor stimulus with random gaps on both channels, verdict
// depends on rwr_pkg, reorder_window_receiver and rwr_checker
module tb_top;
    import rwr_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 65;
    localparam int PHASES        = 4;
    localparam logic [PADDR_W-3:0] REG_SPARE = REG_EXPECTED_MAGIC + 1'b1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MAGIC_W-1:0]  magic_value = '0;
    logic [SEQ_W-1:0]    seq_number = '0;
    logic [LEN_W-1:0]    payload_length = '0;
    logic                end_flag = 1'b0;
    logic [HANDLE_W-1:0] payload_handle = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                result_kind;
    logic [SEQ_W-1:0]    out_sequence;
    logic [LEN_W-1:0]    out_length;
    logic [HANDLE_W-1:0] out_handle;
    logic                out_eof;
    logic                last_of_run;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  result_count;
    int unsigned         items_sent = 0;
    int unsigned         magic_settings = 1;
    logic [SEQ_W-1:0]    seq_base;
    logic                calm_in = 1'b0;
    logic                calm_out = 1'b0;

    always #6 clk = ~clk;

    reorder_window_receiver i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_magic_value    (magic_value),
        .i_seq_number     (seq_number),
        .i_payload_length (payload_length),
        .i_end_flag       (end_flag),
        .i_payload_handle (payload_handle),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (result_kind),
        .o_out_sequence   (out_sequence),
        .o_out_length     (out_length),
        .o_out_handle     (out_handle),
        .o_out_eof        (out_eof),
        .o_last_of_run    (last_of_run),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    rwr_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_magic_value    (magic_value),
        .i_seq_number     (seq_number),
        .i_payload_length (payload_length),
        .i_end_flag       (end_flag),
        .i_payload_handle (payload_handle),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_result_kind    (result_kind),
        .i_out_sequence   (out_sequence),
        .i_out_length     (out_length),
        .i_out_handle     (out_handle),
        .i_out_eof        (out_eof),
        .i_last_of_run    (last_of_run),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count)
    );

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'($urandom_range(1501, 2047));
            2:       return ($urandom_range(0, 1) == 0) ? MAX_LEN : LEN_W'(1);
            default: return LEN_W'($urandom_range(1, 1500));
        endcase
    endfunction

    task automatic send_packet(input logic [MAGIC_W-1:0] magic, input logic [SEQ_W-1:0] seq,
                               input logic [LEN_W-1:0] len, input logic eof,
                               input logic [HANDLE_W-1:0] handle);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        magic_value    <= magic;
        seq_number     <= seq;
        payload_length <= len;
        end_flag       <= eof;
        payload_handle <= handle;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
    endtask

    task automatic write_register(input logic [PADDR_W-3:0] index,
                                  input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // up to one window of sequences in shuffled order with noise mixed in, then
    // in-order resends of whatever could not have been parked
    task automatic send_batch(input logic [MAGIC_W-1:0] magic);
        int unsigned      k;
        int unsigned      j;
        int unsigned      pick;
        int unsigned      swap;
        int unsigned      order [WINDOW_DEPTH];
        logic [15:0]      landed;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
        k = ($urandom_range(0, 3) == 0) ? WINDOW_DEPTH : $urandom_range(1, WINDOW_DEPTH);
        calm_in = ($urandom_range(0, 3) == 0);
        landed = '0;
        for (j = 0; j < k; j++) order[j] = j;
        for (j = k - 1; j > 0; j--) begin
            pick = $urandom_range(0, j);
            swap = order[j];
            order[j] = order[pick];
            order[pick] = swap;
        end
        for (j = 0; j < k; j++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: send_packet(magic ^ (32'h1 << $urandom_range(0, 31)),
                                   seq_base + $urandom_range(0, k - 1), pick_length(),
                                   1'($urandom), 16'($urandom));
                    1: send_packet(magic, seq_base - $urandom_range(1, 20), pick_length(),
                                   1'($urandom), 16'($urandom));
                    2: begin
                        seq = $urandom;
                        if (seq - seq_base < 32'd32) seq = seq ^ 32'h8000_0000;
                        send_packet(magic, seq, pick_length(), 1'($urandom), 16'($urandom));
                    end
                    default: begin
                        pick = $urandom_range(0, k - 1);
                        len = pick_length();
                        send_packet(magic, seq_base + pick, len, 1'b0, 16'($urandom));
                        if (len != '0) landed[pick] = 1'b1;
                    end
                endcase
            end
            len = pick_length();
            send_packet(magic, seq_base + order[j], len, 1'b0, 16'($urandom));
            if (len != '0) landed[order[j]] = 1'b1;
        end
        for (j = 0; j < k; j++)
            if (!landed[j])
                send_packet(magic, seq_base + j, pick_length(), 1'b0, 16'($urandom));
        seq_base = seq_base + k;
    endtask

    initial begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 23) == 0) calm_out = ~calm_out;
            stall = calm_out ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : stimulus
        logic [MAGIC_W-1:0] magic;
        int unsigned        phase_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // magic still at its reset value
        send_packet(32'h0, 32'd1, 11'd100, 1'b0, 16'h0001);
        send_packet(32'h1, 32'd2, 11'd10, 1'b1, 16'hFFFF);
        send_packet(32'h0, 32'd0, 11'd20, 1'b1, 16'h1234);
        send_packet(32'h0, 32'd18, 11'd30, 1'b0, 16'h0018);
        send_packet(32'h0, 32'd17, 11'h7FF, 1'b0, 16'hBEEF);
        send_packet(32'h0, 32'd3, 11'd0, 1'b0, 16'h0303);
        send_packet(32'h0, 32'd4, 11'd5, 1'b0, 16'hAAAA);
        send_packet(32'h0, 32'd4, 11'd7, 1'b0, 16'hBBBB);
        send_packet(32'h0, 32'hFFFF_FFFF, 11'd1, 1'b1, 16'h0000);
        send_packet(32'h0, 32'd2, 11'd0, 1'b0, 16'h0202);
        send_packet(32'h0, 32'd3, 11'd1500, 1'b0, 16'h0003);
        // fill the rest of the window so one in-order item drains it all
        for (int s = 6; s <= 20; s++)
            if (s != 17)
                send_packet(32'h0, s, LEN_W'($urandom_range(1, 1500)), 1'b0, 16'($urandom));
        send_packet(32'h0, 32'd5, 11'd1501, 1'b0, 16'h0005);

        settle();
        write_register(REG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
        write_register(REG_SPARE, 32'h1234_5678);
        magic_settings++;
        magic = 32'hFFFF_FFFF;
        send_packet(magic, 32'd21, 11'd64, 1'b0, 16'h0000);
        send_packet(32'h0, 32'd22, 11'd64, 1'b1, 16'h5555);
        seq_base = 32'd22;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                magic = (p == PHASES - 1) ? 32'h0 : $urandom;
                write_register(REG_EXPECTED_MAGIC, magic);
                magic_settings++;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_batch(magic);
        end

        // end of file, then items that must all be ignored
        calm_in = 1'b0;
        send_packet(magic, seq_base, pick_length(), 1'b1, 16'($urandom));
        send_packet(magic, seq_base + 1, 11'd100, 1'b0, 16'h0101);
        send_packet(magic, seq_base + 1, 11'd200, 1'b1, 16'h0202);
        settle();
        write_register(REG_EXPECTED_MAGIC, ~magic);
        send_packet(~magic, seq_base + 1, 11'd300, 1'b0, 16'h0303);
        settle();

        $display("run covered %0d packet descriptors under %0d magic settings",
                 items_sent, magic_settings);
        $display("%0d results compared, %0d mismatches", result_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
